FILE: rtl/hbf_pkg.sv
// Shared constants, types and codes of the 3x3 height map box filter.
package hbf_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 12;
    localparam int SAMPLE_W     = 8;
    localparam int MEAN_W       = 16;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    // Column sums over three rows and over the two lower rows, and the window sum.
    localparam int FULL_W = SAMPLE_W + 2;
    localparam int LOW_W  = SAMPLE_W + 1;
    localparam int SUM_W  = SAMPLE_W + 4;
    localparam int CNT_W  = 4;

    // Job queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Map size after reset.
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = CFG_IDX_W'(1);

    // Result kinds one sample can cause, in emission order. The inner kinds
    // are centered one column back, the edge kinds on the last column; the
    // previous-row kinds one row back, the last-row kinds on the bottom row.
    localparam int NUM_KINDS       = 4;
    localparam int KIND_PREV_INNER = 0;
    localparam int KIND_PREV_EDGE  = 1;
    localparam int KIND_LAST_INNER = 2;
    localparam int KIND_LAST_EDGE  = 3;

    typedef struct packed {
        logic                   restart;
        logic [COL_W-1:0]       col_last;
        logic [ROW_W-1:0]       row_last;
    } t_frame_cfg;

    typedef struct packed {
        logic [NUM_KINDS-1:0]   kinds;
        logic [COL_W-1:0]       col;
        logic [ROW_W-1:0]       row;
        logic                   col_ge1;
        logic                   col_ge2;
        logic                   row_ge1;
        logic                   row_ge2;
        logic [FULL_W-1:0]      full_p2;
        logic [FULL_W-1:0]      full_p1;
        logic [FULL_W-1:0]      full_c;
        logic [LOW_W-1:0]       low_p2;
        logic [LOW_W-1:0]       low_p1;
        logic [LOW_W-1:0]       low_c;
    } t_job;

endpackage

FILE: rtl/hbf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module hbf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hbf_front.sv
// Front end: sample counters, rotating line stores and column sums that form one job per sample.
module hbf_front import hbf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_frame_cfg          i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_q_full,
    output logic                o_push,
    output t_job                o_job
);

    logic                 accept;
    logic                 col_last;
    logic                 row_last;
    logic                 f1_adv;
    logic [NUM_KINDS-1:0] n_kinds;

    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [1:0]           r_rot;

    logic                 r_f1_valid;
    logic [SAMPLE_W-1:0]  r_f1_sample;
    logic [COL_W-1:0]     r_f1_col;
    logic [ROW_W-1:0]     r_f1_row;
    logic [1:0]           r_f1_rot;
    logic [NUM_KINDS-1:0] r_f1_kinds;
    logic                 r_f1_col_ge1;
    logic                 r_f1_col_ge2;
    logic                 r_f1_row_ge1;
    logic                 r_f1_row_ge2;

    logic [FULL_W-1:0]    r_full_p1;
    logic [FULL_W-1:0]    r_full_p2;
    logic [LOW_W-1:0]     r_low_p1;
    logic [LOW_W-1:0]     r_low_p2;

    logic [SAMPLE_W-1:0]  rd_data [3];
    logic [SAMPLE_W-1:0]  mid;
    logic [SAMPLE_W-1:0]  top;
    logic [FULL_W-1:0]    cur_full;
    logic [LOW_W-1:0]     cur_low;

    assign col_last = (r_col == i_cfg.col_last);
    assign row_last = (r_row == i_cfg.row_last);

    // A job that causes no result never enters the queue.
    assign f1_adv  = r_f1_valid && ((r_f1_kinds == '0) || !i_q_full);
    assign o_ready = !r_f1_valid || f1_adv;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_kinds                  = '0;
        n_kinds[KIND_PREV_INNER] = (r_row != '0) && (r_col != '0);
        n_kinds[KIND_PREV_EDGE]  = (r_row != '0) && col_last;
        n_kinds[KIND_LAST_INNER] = row_last && (r_col != '0);
        n_kinds[KIND_LAST_EDGE]  = row_last && col_last;
    end

    // Position counters and the line store that holds the current row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_col <= '0;
            r_row <= '0;
            r_rot <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row <= '0;
                    r_rot <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    r_rot <= (r_rot == 2'd2) ? 2'd0 : r_rot + 2'd1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (o_ready) begin
            r_f1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_sample  <= i_sample;
            r_f1_col     <= r_col;
            r_f1_row     <= r_row;
            r_f1_rot     <= r_rot;
            r_f1_kinds   <= n_kinds;
            r_f1_col_ge1 <= (r_col != '0);
            r_f1_col_ge2 <= (r_col > COL_W'(1));
            r_f1_row_ge1 <= (r_row != '0);
            r_f1_row_ge2 <= (r_row > ROW_W'(1));
        end
    end

    // Three line stores; each is read at the sample's column every accepted
    // request, and only the current row's store is written.
    for (genvar k = 0; k < 3; k++) begin : g_line
        hbf_ram #(
            .DATA_W (SAMPLE_W),
            .DEPTH  (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (accept && (r_rot == 2'(k))),
            .i_waddr (r_col),
            .i_wdata (i_sample),
            .i_re    (accept),
            .i_raddr (r_col),
            .o_rdata (rd_data[k])
        );
    end

    // The row one back sits in the previous store, two back in the one before.
    always_comb begin
        case (r_f1_rot)
            2'd0: begin
                mid = rd_data[2];
                top = rd_data[1];
            end
            2'd1: begin
                mid = rd_data[0];
                top = rd_data[2];
            end
            2'd2: begin
                mid = rd_data[1];
                top = rd_data[0];
            end
            default: begin
                mid = '0;
                top = '0;
            end
        endcase
    end

    always_comb begin
        cur_low  = LOW_W'(r_f1_sample) + (r_f1_row_ge1 ? LOW_W'(mid) : '0);
        cur_full = FULL_W'(cur_low) + (r_f1_row_ge2 ? FULL_W'(top) : '0);
    end

    // Column sums of the two columns to the left slide along with each sample.
    always_ff @(posedge i_clk) begin
        if (f1_adv) begin
            r_full_p2 <= r_full_p1;
            r_full_p1 <= cur_full;
            r_low_p2  <= r_low_p1;
            r_low_p1  <= cur_low;
        end
    end

    always_comb begin
        o_job.kinds   = r_f1_kinds;
        o_job.col     = r_f1_col;
        o_job.row     = r_f1_row;
        o_job.col_ge1 = r_f1_col_ge1;
        o_job.col_ge2 = r_f1_col_ge2;
        o_job.row_ge1 = r_f1_row_ge1;
        o_job.row_ge2 = r_f1_row_ge2;
        o_job.full_p2 = r_f1_col_ge2 ? r_full_p2 : '0;
        o_job.full_p1 = r_f1_col_ge1 ? r_full_p1 : '0;
        o_job.full_c  = cur_full;
        o_job.low_p2  = r_f1_col_ge2 ? r_low_p2 : '0;
        o_job.low_p1  = r_f1_col_ge1 ? r_low_p1 : '0;
        o_job.low_c   = cur_low;
    end

    assign o_push = f1_adv && (r_f1_kinds != '0);

endmodule

FILE: rtl/hbf_queue.sv
// Short job queue that decouples the front end from the back end.
module hbf_queue import hbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

FILE: rtl/hbf_back.sv
// Back end: walks job results, one per cycle unless stalled; scales the window mean.
module hbf_back import hbf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [COL_W-1:0]    o_col,
    output logic [ROW_W-1:0]    o_row,
    output logic [MEAN_W-1:0]   o_mean_height,
    output logic                o_run_end,
    output logic                o_frame_end
);

    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 16;

    // 256 * 2^16 / count, rounded up; exact after truncation for any window sum.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            CNT_W'(1): m = RECIP_W'(16777216);
            CNT_W'(2): m = RECIP_W'(8388608);
            CNT_W'(3): m = RECIP_W'(5592406);
            CNT_W'(4): m = RECIP_W'(4194304);
            CNT_W'(6): m = RECIP_W'(2796203);
            CNT_W'(9): m = RECIP_W'(1864136);
            default:   m = '0;
        endcase
        return m;
    endfunction

    logic [NUM_KINDS-1:0] r_done;
    logic [NUM_KINDS-1:0] pending;
    logic [NUM_KINDS-1:0] pick;
    logic [NUM_KINDS-1:0] rest;
    logic                 sel;
    logic                 out_adv;
    logic                 s1_adv;

    logic [1:0]           ncol3;
    logic [1:0]           ncol2;
    logic [1:0]           nrow3;
    logic [1:0]           nrow2;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_count;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;

    logic                 r_s1_valid;
    logic [SUM_W-1:0]     r_s1_sum;
    logic [CNT_W-1:0]     r_s1_count;
    logic [COL_W-1:0]     r_s1_col;
    logic [ROW_W-1:0]     r_s1_row;
    logic                 r_s1_run_end;
    logic                 r_s1_frame_end;

    logic [SUM_W+RECIP_W-1:0] prod;

    logic                 r_o_valid;
    logic [COL_W-1:0]     r_o_col;
    logic [ROW_W-1:0]     r_o_row;
    logic [MEAN_W-1:0]    r_o_mean;
    logic                 r_o_run_end;
    logic                 r_o_frame_end;

    assign out_adv = !r_o_valid || i_ready;
    assign s1_adv  = !r_s1_valid || out_adv;

    // Lowest kind still owed by the job at the head of the queue.
    assign pending = i_job.kinds & ~r_done;
    assign pick    = pending & (~pending + 1'b1);
    assign rest    = pending & ~pick;
    assign sel     = i_job_valid && s1_adv;
    assign o_pop   = sel && (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (sel) begin
            r_done <= (rest == '0) ? '0 : (r_done | pick);
        end
    end

    always_comb begin
        ncol3 = i_job.col_ge2 ? 2'd3 : 2'd2;
        ncol2 = i_job.col_ge1 ? 2'd2 : 2'd1;
        nrow3 = i_job.row_ge2 ? 2'd3 : 2'd2;
        nrow2 = i_job.row_ge1 ? 2'd2 : 2'd1;
        if (pick[KIND_PREV_INNER]) begin
            n_sum   = SUM_W'(i_job.full_p2) + SUM_W'(i_job.full_p1) + SUM_W'(i_job.full_c);
            n_count = CNT_W'(ncol3) * CNT_W'(nrow3);
            n_col   = i_job.col - 1'b1;
            n_row   = i_job.row - 1'b1;
        end else if (pick[KIND_PREV_EDGE]) begin
            n_sum   = SUM_W'(i_job.full_p1) + SUM_W'(i_job.full_c);
            n_count = CNT_W'(ncol2) * CNT_W'(nrow3);
            n_col   = i_job.col;
            n_row   = i_job.row - 1'b1;
        end else if (pick[KIND_LAST_INNER]) begin
            n_sum   = SUM_W'(i_job.low_p2) + SUM_W'(i_job.low_p1) + SUM_W'(i_job.low_c);
            n_count = CNT_W'(ncol3) * CNT_W'(nrow2);
            n_col   = i_job.col - 1'b1;
            n_row   = i_job.row;
        end else begin
            n_sum   = SUM_W'(i_job.low_p1) + SUM_W'(i_job.low_c);
            n_count = CNT_W'(ncol2) * CNT_W'(nrow2);
            n_col   = i_job.col;
            n_row   = i_job.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_s1_sum       <= n_sum;
            r_s1_count     <= n_count;
            r_s1_col       <= n_col;
            r_s1_row       <= n_row;
            r_s1_run_end   <= (rest == '0);
            r_s1_frame_end <= pick[KIND_LAST_EDGE];
        end
    end

    assign prod = (SUM_W+RECIP_W)'(r_s1_sum) * (SUM_W+RECIP_W)'(recip(r_s1_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_o_col       <= r_s1_col;
            r_o_row       <= r_s1_row;
            r_o_mean      <= prod[RECIP_SHIFT +: MEAN_W];
            r_o_run_end   <= r_s1_run_end;
            r_o_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_col         = r_o_col;
    assign o_row         = r_o_row;
    assign o_mean_height = r_o_mean;
    assign o_run_end     = r_o_run_end;
    assign o_frame_end   = r_o_frame_end;

endmodule

FILE: rtl/heightmap_box_filter_3x3.sv
// Results pass the front register, the job queue, then the back-end sum and mean registers.
// Throughput: one sample per cycle while the job queue has room; each result takes its own
// turn on the single back-end result path, so a sample at a row end or on the bottom row (up to
// two results, four at the bottom right corner) holds input once the four-entry job queue fills.
// Reset (synchronous, active low) clears counters, queue and valid flags; map size returns to
// 1024 by 1024. The line stores are not cleared and need no clearing pass.
module heightmap_box_filter_3x3 import hbf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Sample input channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // Result output channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COL_W-1:0]      o_col,
    output logic [ROW_W-1:0]      o_row,
    output logic [MEAN_W-1:0]     o_mean_height,
    output logic                  o_run_end,
    output logic                  o_frame_end
);

    // Map size is held as the index of the last column and the last row, so
    // the front end only compares against it. A width of zero acts as one and
    // a width beyond the line store acts as the full line store; a height of
    // zero acts as one.
    localparam int RESET_COLS = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic                     cfg_wr;
    logic [WIDTH_CFG_W-1:0]   cfg_width;
    logic [HEIGHT_CFG_W-1:0]  cfg_height;
    logic [COL_W-1:0]         n_col_last;
    logic [ROW_W-1:0]         n_row_last;
    logic [COL_W-1:0]         r_col_last;
    logic [ROW_W-1:0]         r_row_last;
    t_frame_cfg               frame_cfg;

    logic                     q_push;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_pop;
    t_job                     push_job;
    t_job                     head_job;

    // Configuration requests are always taken at once.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_width   = i_cfg_data[WIDTH_CFG_W-1:0];
    assign cfg_height  = i_cfg_data[HEIGHT_CFG_W-1:0];

    always_comb begin
        if (cfg_width == '0) begin
            n_col_last = '0;
        end else if (int'(cfg_width) > MAX_WIDTH) begin
            n_col_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_col_last = COL_W'(cfg_width - 1'b1);
        end
        n_row_last = (cfg_height == '0) ? '0 : ROW_W'(cfg_height - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_W'(RESET_COLS - 1);
            r_row_last <= ROW_W'(RESET_HEIGHT - 1);
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_MAP_WIDTH) begin
                r_col_last <= n_col_last;
            end
            if (i_cfg_index == CFG_MAP_HEIGHT) begin
                r_row_last <= n_row_last;
            end
        end
    end

    // A write to either register restarts the frame at the top left corner;
    // a write to an unknown index changes nothing.
    always_comb begin
        frame_cfg.restart  = cfg_wr && ((i_cfg_index == CFG_MAP_WIDTH) ||
                                        (i_cfg_index == CFG_MAP_HEIGHT));
        frame_cfg.col_last = r_col_last;
        frame_cfg.row_last = r_row_last;
    end

    // The front end stores each sample in the line stores, builds the three
    // column sums around it and turns it into one job listing the results it
    // causes.
    hbf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (frame_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    // Jobs wait here so that a sample with several results does not stall
    // the line store pipeline right away.
    hbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    // The back end emits the results of a job in raster order, one per cycle while the
    // output is not stalled, dividing by the neighbor count through a reciprocal multiply.
    hbf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_col         (o_col),
        .o_row         (o_row),
        .o_mean_height (o_mean_height),
        .o_run_end     (o_run_end),
        .o_frame_end   (o_frame_end)
    );

endmodule

FILE: rtl/hbf_checker.sv
// Port-level checks for the 3x3 height map box filter, bound to the top level.
module hbf_checker import hbf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  logic [COL_W-1:0]      o_col,
    input  logic [ROW_W-1:0]      o_row,
    input  logic [MEAN_W-1:0]     o_mean_height,
    input  logic                  o_run_end,
    input  logic                  o_frame_end
);

    // A stalled result request keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_col) && $stable(o_row) &&
                                $stable(o_mean_height) && $stable(o_run_end) &&
                                $stable(o_frame_end))
        else $error("result request changed while stalled");

    // The bottom right corner is always the last result of its sample.
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_run_end)
        else $error("frame end without run end");

    // A mean of 8-bit samples never exceeds 255 in 8.8 form.
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mean_height <= MEAN_W'(16'hFF00)))
        else $error("mean out of range");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind heightmap_box_filter_3x3 hbf_checker u_hbf_checker (.*);
